[hdl/prlf_pkg.sv]
package prlf_pkg;

  localparam int ID_W        = 32;
  localparam int QTY_W       = 31;
  localparam int SUM_W       = 35;
  localparam int PROD_W      = 2 * QTY_W;
  localparam int REM_W       = SUM_W + 1;
  localparam int STEP_W      = $clog2(QTY_W);
  localparam int MAX_RESULTS = 16;
  localparam int LEVEL_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_CANCEL  = 2'd1,
    ACT_AGGRESS = 2'd2,
    ACT_BAD     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_FILL      = 2'd0,
    KIND_INSERTED  = 2'd1,
    KIND_CANCELLED = 2'd2,
    KIND_REJECTED  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_LINIT,
    ST_RANK,
    ST_CNT,
    ST_PICK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [QTY_W-1:0]  qty;
    logic              qty_zero;
  } item_t;

endpackage

[hdl/prlf_front.sv]
module prlf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [prlf_pkg::ID_W-1:0] in_order_id,
  input  logic [prlf_pkg::QTY_W-1:0] in_quantity,
  output logic                      q_valid,
  output prlf_pkg::item_t           q_item,
  input  logic                      q_pop
);

  prlf_pkg::item_t fifo_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  prlf_pkg::item_t cls;

  always_comb begin
    cls.id       = in_order_id;
    cls.qty      = in_quantity;
    cls.qty_zero = (in_quantity == '0);
    cls.op       = prlf_pkg::op_t'(in_action);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[hdl/prlf_back.sv]
module prlf_back #(
  parameter int LEVEL_DEPTH = prlf_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  prlf_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [prlf_pkg::ID_W-1:0]   out_resting_id,
  output logic [prlf_pkg::QTY_W-1:0]  out_fill_quantity,
  output logic [prlf_pkg::QTY_W-1:0]  out_resting_left,
  output logic [prlf_pkg::QTY_W-1:0]  out_aggressor_left,
  output logic                        out_last
);

  localparam int LvlCap = (LEVEL_DEPTH < prlf_pkg::MAX_RESULTS) ?
                          LEVEL_DEPTH : prlf_pkg::MAX_RESULTS;
  localparam int IdxW = $clog2(LvlCap);
  localparam int CntW = $clog2(LvlCap + 1);
  localparam logic [IdxW-1:0] JLast = IdxW'(LvlCap - 1);
  localparam int IdW  = prlf_pkg::ID_W;
  localparam int QW   = prlf_pkg::QTY_W;
  localparam int SW   = prlf_pkg::SUM_W;
  localparam int PW   = prlf_pkg::PROD_W;
  localparam int RW   = prlf_pkg::REM_W;
  localparam int KW   = prlf_pkg::STEP_W;

  prlf_pkg::state_t st_r, st_nxt;

  logic [IdW-1:0] slot_id_r [LvlCap];
  logic [IdW-1:0] slot_id_nxt [LvlCap];
  logic [QW-1:0]  slot_q_r [LvlCap];
  logic [QW-1:0]  slot_q_nxt [LvlCap];
  logic [QW-1:0]  fill_r [LvlCap];
  logic [QW-1:0]  fill_nxt [LvlCap];
  logic [LvlCap-1:0] valid_r, valid_nxt;
  logic [LvlCap-1:0] done_r, done_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;

  prlf_pkg::op_t  op_r, op_nxt;
  logic [IdW-1:0] id_r, id_nxt;
  logic [QW-1:0]  qty_r, qty_nxt;
  logic           qzero_r, qzero_nxt;

  logic [IdxW-1:0] j_r, j_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [RW-1:0]   drem_r, drem_nxt;
  logic [QW-1:0]   dlo_r, dlo_nxt;
  logic [SW-1:0]   alloc_r, alloc_nxt;
  logic [CntW-1:0] left_r, left_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] nfill_r, nfill_nxt;

  logic            found_r, found_nxt;
  logic [IdxW-1:0] best_idx_r, best_idx_nxt;
  logic [IdW-1:0]  best_id_r, best_id_nxt;
  logic [QW-1:0]   best_q_r, best_q_nxt;
  logic [QW-1:0]   best_fill_r, best_fill_nxt;
  logic [QW-1:0]   aggr_r, aggr_nxt;

  prlf_pkg::kind_t res_kind_r, res_kind_nxt;
  logic [IdW-1:0]  res_id_r, res_id_nxt;
  logic [QW-1:0]   res_fill_r, res_fill_nxt;
  logic [QW-1:0]   res_left_r, res_left_nxt;
  logic [QW-1:0]   res_aggr_r, res_aggr_nxt;
  logic            res_last_r, res_last_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_kind_r, out_kind_nxt;
  logic [IdW-1:0]  out_id_r, out_id_nxt;
  logic [QW-1:0]   out_fill_r, out_fill_nxt;
  logic [QW-1:0]   out_left_r, out_left_nxt;
  logic [QW-1:0]   out_aggr_r, out_aggr_nxt;
  logic            out_last_r, out_last_nxt;

  logic [LvlCap-1:0] hit;
  logic [IdxW-1:0]   hit_idx, free_idx;
  logic              full;
  logic              out_free;
  logic [RW-1:0]     shifted, diffv;
  logic              ge;
  logic [QW-1:0]     quo;
  logic              elig, take, fin_found;
  logic [IdxW-1:0]   fin_idx;
  logic [IdW-1:0]    fin_id;
  logic [QW-1:0]     fin_q, fin_fill, new_q;
  logic [CntW-1:0]   cnt_fin;

  always_comb begin
    hit      = '0;
    hit_idx  = '0;
    free_idx = '0;
    full     = 1'b1;
    for (int i = LvlCap - 1; i >= 0; i--) begin
      hit[i] = valid_r[i] && (slot_id_r[i] == id_r);
      if (hit[i]) begin
        hit_idx = IdxW'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IdxW'(i);
        full     = 1'b0;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign shifted  = {drem_r[RW-2:0], dlo_r[QW-1]};
  assign diffv    = shifted - RW'(sum_r);
  assign ge       = (shifted >= RW'(sum_r));
  assign quo      = {dlo_r[QW-2:0], ge};

  always_comb begin
    st_nxt      = st_r;
    slot_id_nxt = slot_id_r;
    slot_q_nxt  = slot_q_r;
    fill_nxt    = fill_r;
    valid_nxt   = valid_r;
    done_nxt    = done_r;
    sum_nxt     = sum_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    qty_nxt     = qty_r;
    qzero_nxt   = qzero_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    prod_nxt    = prod_r;
    drem_nxt    = drem_r;
    dlo_nxt     = dlo_r;
    alloc_nxt   = alloc_r;
    left_nxt    = left_r;
    cnt_nxt     = cnt_r;
    nfill_nxt   = nfill_r;
    found_nxt   = found_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    best_q_nxt    = best_q_r;
    best_fill_nxt = best_fill_r;
    aggr_nxt      = aggr_r;
    res_kind_nxt  = res_kind_r;
    res_id_nxt    = res_id_r;
    res_fill_nxt  = res_fill_r;
    res_left_nxt  = res_left_r;
    res_aggr_nxt  = res_aggr_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_fill_nxt  = out_fill_r;
    out_left_nxt  = out_left_r;
    out_aggr_nxt  = out_aggr_r;
    out_last_nxt  = out_last_r;
    q_pop     = 1'b0;
    elig      = 1'b0;
    take      = 1'b0;
    fin_found = 1'b0;
    fin_idx   = '0;
    fin_id    = '0;
    fin_q     = '0;
    fin_fill  = '0;
    new_q     = '0;
    cnt_fin   = '0;

    unique case (st_r)
      prlf_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_item.op;
          id_nxt    = q_item.id;
          qty_nxt   = q_item.qty;
          qzero_nxt = q_item.qty_zero;
          st_nxt    = prlf_pkg::ST_DECODE;
        end
      end

      prlf_pkg::ST_DECODE: begin
        res_kind_nxt = prlf_pkg::KIND_REJECTED;
        res_id_nxt   = id_r;
        res_fill_nxt = '0;
        res_left_nxt = '0;
        res_aggr_nxt = '0;
        res_last_nxt = 1'b1;
        st_nxt       = prlf_pkg::ST_EMIT;
        unique case (op_r)
          prlf_pkg::ACT_INSERT: begin
            if (!qzero_r && (hit == '0) && !full) begin
              valid_nxt[free_idx]   = 1'b1;
              slot_id_nxt[free_idx] = id_r;
              slot_q_nxt[free_idx]  = qty_r;
              sum_nxt      = sum_r + SW'(qty_r);
              res_kind_nxt = prlf_pkg::KIND_INSERTED;
              res_left_nxt = qty_r;
            end
          end
          prlf_pkg::ACT_CANCEL: begin
            if (hit != '0) begin
              valid_nxt[hit_idx] = 1'b0;
              sum_nxt      = sum_r - SW'(slot_q_r[hit_idx]);
              res_kind_nxt = prlf_pkg::KIND_CANCELLED;
            end
          end
          prlf_pkg::ACT_AGGRESS: begin
            res_aggr_nxt = qty_r;
            done_nxt     = '0;
            j_nxt        = '0;
            if (qzero_r || (valid_r == '0) || (sum_r == '0)) begin
              st_nxt = prlf_pkg::ST_EMIT;
            end else if (SW'(qty_r) >= sum_r) begin
              fill_nxt = slot_q_r;
              aggr_nxt = qty_r - sum_r[QW-1:0];
              cnt_nxt  = '0;
              st_nxt   = prlf_pkg::ST_CNT;
            end else begin
              aggr_nxt  = '0;
              alloc_nxt = '0;
              st_nxt    = prlf_pkg::ST_MUL;
            end
          end
          default: begin
          end
        endcase
      end

      prlf_pkg::ST_MUL: begin
        if (valid_r[j_r]) begin
          prod_nxt = PW'(qty_r) * PW'(slot_q_r[j_r]);
          st_nxt   = prlf_pkg::ST_DINIT;
        end else begin
          fill_nxt[j_r] = '0;
          if (j_r == JLast) begin
            st_nxt = prlf_pkg::ST_LINIT;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end

      prlf_pkg::ST_DINIT: begin
        drem_nxt = RW'(prod_r[PW-1:QW]);
        dlo_nxt  = prod_r[QW-1:0];
        k_nxt    = '0;
        st_nxt   = prlf_pkg::ST_DIV;
      end

      prlf_pkg::ST_DIV: begin
        drem_nxt = ge ? diffv : shifted;
        dlo_nxt  = quo;
        k_nxt    = k_r + 1'b1;
        if (k_r == KW'(QW - 1)) begin
          fill_nxt[j_r] = quo;
          alloc_nxt     = alloc_r + SW'(quo);
          if (j_r == JLast) begin
            st_nxt = prlf_pkg::ST_LINIT;
          end else begin
            j_nxt  = j_r + 1'b1;
            st_nxt = prlf_pkg::ST_MUL;
          end
        end
      end

      prlf_pkg::ST_LINIT: begin
        left_nxt  = CntW'(SW'(qty_r) - alloc_r);
        j_nxt     = '0;
        found_nxt = 1'b0;
        cnt_nxt   = '0;
        if (SW'(qty_r) == alloc_r) begin
          st_nxt = prlf_pkg::ST_CNT;
        end else begin
          st_nxt = prlf_pkg::ST_RANK;
        end
      end

      prlf_pkg::ST_RANK: begin
        elig = valid_r[j_r] && !done_r[j_r] && (fill_r[j_r] < slot_q_r[j_r]);
        take = elig && (!found_r || (slot_q_r[j_r] > best_q_r) ||
               ((slot_q_r[j_r] == best_q_r) && (slot_id_r[j_r] < best_id_r)));
        if (take) begin
          found_nxt    = 1'b1;
          best_idx_nxt = j_r;
          best_q_nxt   = slot_q_r[j_r];
          best_id_nxt  = slot_id_r[j_r];
        end
        j_nxt = j_r + 1'b1;
        if (j_r == JLast) begin
          fin_found = found_r || take;
          fin_idx   = take ? j_r : best_idx_r;
          j_nxt     = '0;
          found_nxt = 1'b0;
          if (!fin_found) begin
            done_nxt = '0;
            cnt_nxt  = '0;
            st_nxt   = prlf_pkg::ST_CNT;
          end else begin
            done_nxt[fin_idx] = 1'b1;
            fill_nxt[fin_idx] = fill_r[fin_idx] + 1'b1;
            left_nxt          = left_r - 1'b1;
            if (left_r == CntW'(1)) begin
              done_nxt = '0;
              cnt_nxt  = '0;
              st_nxt   = prlf_pkg::ST_CNT;
            end
          end
        end
      end

      prlf_pkg::ST_CNT: begin
        cnt_fin = cnt_r + CntW'(valid_r[j_r] && (fill_r[j_r] != '0));
        cnt_nxt = cnt_fin;
        j_nxt   = j_r + 1'b1;
        if (j_r == JLast) begin
          j_nxt     = '0;
          found_nxt = 1'b0;
          nfill_nxt = cnt_fin;
          if (cnt_fin == '0) begin
            res_kind_nxt = prlf_pkg::KIND_REJECTED;
            res_id_nxt   = id_r;
            res_fill_nxt = '0;
            res_left_nxt = '0;
            res_aggr_nxt = qty_r;
            res_last_nxt = 1'b1;
            st_nxt       = prlf_pkg::ST_EMIT;
          end else begin
            st_nxt = prlf_pkg::ST_PICK;
          end
        end
      end

      prlf_pkg::ST_PICK: begin
        elig = valid_r[j_r] && !done_r[j_r];
        take = elig && (!found_r || (slot_id_r[j_r] < best_id_r));
        if (take) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = j_r;
          best_id_nxt   = slot_id_r[j_r];
          best_q_nxt    = slot_q_r[j_r];
          best_fill_nxt = fill_r[j_r];
        end
        j_nxt = j_r + 1'b1;
        if (j_r == JLast) begin
          fin_found = found_r || take;
          fin_idx   = take ? j_r : best_idx_r;
          fin_id    = take ? slot_id_r[j_r] : best_id_r;
          fin_q     = take ? slot_q_r[j_r] : best_q_r;
          fin_fill  = take ? fill_r[j_r] : best_fill_r;
          new_q     = fin_q - fin_fill;
          j_nxt     = '0;
          found_nxt = 1'b0;
          if (!fin_found) begin
            st_nxt = prlf_pkg::ST_IDLE;
          end else begin
            done_nxt[fin_idx] = 1'b1;
            if (fin_fill != '0) begin
              slot_q_nxt[fin_idx] = new_q;
              if (new_q == '0) begin
                valid_nxt[fin_idx] = 1'b0;
              end
              sum_nxt      = sum_r - SW'(fin_fill);
              nfill_nxt    = nfill_r - 1'b1;
              res_kind_nxt = prlf_pkg::KIND_FILL;
              res_id_nxt   = fin_id;
              res_fill_nxt = fin_fill;
              res_left_nxt = new_q;
              res_aggr_nxt = aggr_r;
              res_last_nxt = (nfill_r == CntW'(1));
              st_nxt       = prlf_pkg::ST_EMIT;
            end
          end
        end
      end

      prlf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_id_nxt    = res_id_r;
          out_fill_nxt  = res_fill_r;
          out_left_nxt  = res_left_r;
          out_aggr_nxt  = res_aggr_r;
          out_last_nxt  = res_last_r;
          j_nxt         = '0;
          found_nxt     = 1'b0;
          st_nxt        = res_last_r ? prlf_pkg::ST_IDLE : prlf_pkg::ST_PICK;
        end
      end

      default: begin
        st_nxt = prlf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= prlf_pkg::ST_IDLE;
      valid_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      k_r         <= '0;
      found_r     <= 1'b0;
      done_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      valid_r     <= valid_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
      done_r      <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_id_r   <= slot_id_nxt;
    slot_q_r    <= slot_q_nxt;
    fill_r      <= fill_nxt;
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    qty_r       <= qty_nxt;
    qzero_r     <= qzero_nxt;
    prod_r      <= prod_nxt;
    drem_r      <= drem_nxt;
    dlo_r       <= dlo_nxt;
    alloc_r     <= alloc_nxt;
    left_r      <= left_nxt;
    cnt_r       <= cnt_nxt;
    nfill_r     <= nfill_nxt;
    best_idx_r  <= best_idx_nxt;
    best_id_r   <= best_id_nxt;
    best_q_r    <= best_q_nxt;
    best_fill_r <= best_fill_nxt;
    aggr_r      <= aggr_nxt;
    res_kind_r  <= res_kind_nxt;
    res_id_r    <= res_id_nxt;
    res_fill_r  <= res_fill_nxt;
    res_left_r  <= res_left_nxt;
    res_aggr_r  <= res_aggr_nxt;
    res_last_r  <= res_last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_fill_r  <= out_fill_nxt;
    out_left_r  <= out_left_nxt;
    out_aggr_r  <= out_aggr_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_resting_id     = out_id_r;
  assign out_fill_quantity  = out_fill_r;
  assign out_resting_left   = out_left_r;
  assign out_aggressor_left = out_aggr_r;
  assign out_last           = out_last_r;

endmodule

[hdl/pro_rata_level_fill.sv]
// Insert, cancel and unknown actions pass through the input queue and the back end's IDLE, DECODE
// and EMIT states to a registered result word; the back end takes the next queued word only in IDLE.
// An aggress below the level total runs a multiply and 31 steps of a one-bit-per-cycle divider per
// resting order, skipping empty slots; then one scan of the D slots per leftover unit, one to count
// fills, and one per order picked in id order plus each fill word; D is LEVEL_DEPTH up to 16.
// A two-word input queue; synchronous active-low reset empties queue and level, drops out_valid.
module pro_rata_level_fill #(
  parameter int LEVEL_DEPTH = prlf_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [prlf_pkg::ID_W-1:0]   in_order_id,
  input  logic [prlf_pkg::QTY_W-1:0]  in_quantity,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [prlf_pkg::ID_W-1:0]   out_resting_id,
  output logic [prlf_pkg::QTY_W-1:0]  out_fill_quantity,
  output logic [prlf_pkg::QTY_W-1:0]  out_resting_left,
  output logic [prlf_pkg::QTY_W-1:0]  out_aggressor_left,
  output logic                        out_last
);

  logic            q_valid;
  logic            q_pop;
  prlf_pkg::item_t q_item;

  prlf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_order_id (in_order_id),
    .in_quantity (in_quantity),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  prlf_back #(
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_resting_id     (out_resting_id),
    .out_fill_quantity  (out_fill_quantity),
    .out_resting_left   (out_resting_left),
    .out_aggressor_left (out_aggressor_left),
    .out_last           (out_last)
  );

endmodule

[hdl/prlf_check.sv]
module prlf_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_kind,
  input logic [prlf_pkg::ID_W-1:0]   out_resting_id,
  input logic [prlf_pkg::QTY_W-1:0]  out_fill_quantity,
  input logic [prlf_pkg::QTY_W-1:0]  out_resting_left,
  input logic [prlf_pkg::QTY_W-1:0]  out_aggressor_left,
  input logic                        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_resting_id) &&
      $stable(out_fill_quantity) && $stable(out_last))
    else $error("stalled output word changed");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == prlf_pkg::KIND_FILL) |-> out_fill_quantity != '0)
    else $error("fill word with zero quantity");

  a_nonfill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != prlf_pkg::KIND_FILL) |-> out_fill_quantity == '0 && out_last)
    else $error("non-fill word carries a fill or is not last");

  a_reject_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == prlf_pkg::KIND_REJECTED || out_kind == prlf_pkg::KIND_CANCELLED)
      |-> out_resting_left == '0)
    else $error("rejected or cancelled word with resting quantity");

endmodule

bind pro_rata_level_fill prlf_check u_prlf_check (.*);
